// ===== sv/kvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared widths, operation codes and status codes of the key-value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

   localparam int FUNC_W          = 2;
   localparam int KEY_W           = 32;
   localparam int VALUE_W         = 32;
   localparam int STATUS_W        = 3;
   localparam int ENTRIES_DEFAULT = 16;

   // Operation codes; the fourth code has no meaning and answers a miss.
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_HIT     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NEW     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_UPDATED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd4;

endpackage
`default_nettype wire

// ===== sv/kvt_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_req_if
// Request channel of the key-value table: operation, key and value.
// ----------------------------------------------------------------------------
interface kvt_req_if
   import kvt_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic signed [KEY_W-1:0]   key;
   logic [VALUE_W-1:0]        value;

   modport source (output valid, output func, output key, output value, input ready);
   modport sink   (input valid, input func, input key, input value, output ready);
endinterface
`default_nettype wire

// ===== sv/kvt_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_rsp_if
// Response channel of the key-value table: status, echoed key and value.
// ----------------------------------------------------------------------------
interface kvt_rsp_if
   import kvt_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [KEY_W-1:0]   key_out;
   logic [VALUE_W-1:0]        value_out;

   modport source (output valid, output status, output key_out, output value_out,
                   input ready);
   modport sink   (input valid, input status, input key_out, input value_out,
                   output ready);
endinterface
`default_nettype wire

// ===== sv/key_value_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_value_table_unit
// Bounded associative table of ENTRIES slots: lookup, delete, insert/update.
// ----------------------------------------------------------------------------
// A request passes through the states SCAN, LAST and WRITE from its transfer
// until its response is loaded into the output register. SCAN reads the key
// memory slot by slot through its single read port and judges the slot read
// before, LAST judges the last slot and WRITE writes back. One request is in
// work at a time. The unit is ready again once the response is loaded, so a
// request transfers only after the previous one is through. The next request
// transfers once the previous response has been loaded, even if that response
// has not yet been taken. A response still waiting in the output register
// holds the write-back, and with it the input, until that response is taken.
// After reset the unit clears the valid marks in the key memory slot by slot
// and accepts no request during that time. An insert of a new key takes the
// lowest-numbered free slot.
module key_value_table_unit
   import kvt_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  wire              clock,
   input  wire              reset,
   kvt_req_if.sink          req_if,
   kvt_rsp_if.source        rsp_if
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_WRITE
   } state_type;

   // Key memory holds the valid mark on top of the key.
   logic [KEY_W:0]            kv_mem [ENTRIES];
   logic [VALUE_W-1:0]        val_mem [ENTRIES];
   logic [KEY_W:0]            kv_rd_ff;
   logic [VALUE_W-1:0]        val_rd_ff;

   state_type                 state_ff;
   logic [IDX_W-1:0]          scan_idx_ff;
   logic                      eval_vld_ff;
   logic [IDX_W-1:0]          eval_idx_ff;

   logic [FUNC_W-1:0]         func_ff;
   logic signed [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0]        value_ff;

   logic                      hit_ff;
   logic [IDX_W-1:0]          hit_idx_ff;
   logic [VALUE_W-1:0]        hit_val_ff;
   logic                      free_ff;
   logic [IDX_W-1:0]          free_idx_ff;

   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic signed [KEY_W-1:0]   rsp_key_ff;
   logic [VALUE_W-1:0]        rsp_value_ff;

   logic                      entry_match;
   logic                      entry_free;
   logic                      wb_go;
   logic                      kv_we;
   logic [IDX_W-1:0]          kv_waddr;
   logic [KEY_W:0]            kv_wdata;
   logic                      val_we;
   logic [IDX_W-1:0]          val_waddr;
   logic [STATUS_W-1:0]       status_in;
   logic [VALUE_W-1:0]        value_out_in;

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.key_out   = rsp_key_ff;
   assign rsp_if.value_out = rsp_value_ff;

   // Slot read from the key memory register, judged against the request.
   assign entry_match = eval_vld_ff && kv_rd_ff[KEY_W] &&
                        (kv_rd_ff[KEY_W-1:0] == key_ff);
   assign entry_free  = eval_vld_ff && !kv_rd_ff[KEY_W];

   assign wb_go = (state_ff == ST_WRITE) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      kv_we        = 1'b0;
      kv_waddr     = scan_idx_ff;
      kv_wdata     = '0;
      val_we       = 1'b0;
      val_waddr    = hit_idx_ff;
      status_in    = STATUS_MISS;
      value_out_in = '0;
      if (state_ff == ST_CLEAR) begin
         kv_we = 1'b1;
      end
      case (func_ff)
         FUNC_LOOKUP: begin
            if (hit_ff) begin
               status_in    = STATUS_HIT;
               value_out_in = hit_val_ff;
            end
         end
         FUNC_DELETE: begin
            if (hit_ff) begin
               status_in    = STATUS_HIT;
               value_out_in = hit_val_ff;
               if (wb_go) begin
                  kv_we    = 1'b1;
                  kv_waddr = hit_idx_ff;
                  kv_wdata = {1'b0, key_ff};
               end
            end
         end
         FUNC_INSERT: begin
            if (hit_ff) begin
               status_in = STATUS_UPDATED;
               val_we    = wb_go;
            end else if (free_ff) begin
               status_in = STATUS_NEW;
               val_we    = wb_go;
               val_waddr = free_idx_ff;
               if (wb_go) begin
                  kv_we    = 1'b1;
                  kv_waddr = free_idx_ff;
                  kv_wdata = {1'b1, key_ff};
               end
            end else begin
               status_in = STATUS_FULL;
            end
         end
         default: begin
            status_in = STATUS_MISS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (kv_we) begin
         kv_mem[kv_waddr] <= kv_wdata;
      end
      kv_rd_ff <= kv_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= value_ff;
      end
      val_rd_ff <= val_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_idx_ff  <= '0;
         eval_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         eval_vld_ff <= (state_ff == ST_SCAN);
         eval_idx_ff <= scan_idx_ff;
         if (wb_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (entry_match) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= eval_idx_ff;
            hit_val_ff <= val_rd_ff;
         end
         if (entry_free && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= eval_idx_ff;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (scan_idx_ff == LAST_IDX) begin
                  scan_idx_ff <= '0;
                  state_ff    <= ST_IDLE;
               end else begin
                  scan_idx_ff <= scan_idx_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_if.valid) begin
                  func_ff     <= req_if.func;
                  key_ff      <= req_if.key;
                  value_ff    <= req_if.value;
                  hit_ff      <= 1'b0;
                  free_ff     <= 1'b0;
                  scan_idx_ff <= '0;
                  state_ff    <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_idx_ff == LAST_IDX) begin
                  scan_idx_ff <= '0;
                  state_ff    <= ST_LAST;
               end else begin
                  scan_idx_ff <= scan_idx_ff + 1'b1;
               end
            end
            ST_LAST: begin
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               if (wb_go) begin
                  rsp_status_ff <= status_in;
                  rsp_key_ff    <= key_ff;
                  rsp_value_ff  <= value_out_in;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for key_value_table_unit. Lookup, delete and
// insert/update requests are sent over the request channel. A behavioral
// copy of the table predicts each response, and the responses are compared
// in order. The run covers a directed fill-to-full sequence, random traffic
// under changing idle patterns, and one long response stall.
// ----------------------------------------------------------------------------
module tb;
   import kvt_pkg::*;

   localparam int TABLE_SLOTS   = ENTRIES_DEFAULT;
   localparam int KEY_POOL_SIZE = 20;
   localparam int RANDOM_ITEMS  = 650;
   localparam int LONG_HOLD     = 80;
   localparam int DRAIN_CYCLES  = TABLE_SLOTS + 24;
   localparam int CYCLE_LIMIT   = 200000;

   // The fourth operation code has no package name; it must answer a miss.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]       func;
      logic signed [KEY_W-1:0] key;
      logic [VALUE_W-1:0]      value;
   } table_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [KEY_W-1:0] key;
      logic [VALUE_W-1:0]      value;
   } table_response_type;

   logic clock;
   logic reset;

   kvt_req_if req_ch ();
   kvt_rsp_if rsp_ch ();

   key_value_table_unit #(
      .ENTRIES (TABLE_SLOTS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   table_request_type       pending_requests[$];
   table_response_type      awaited_responses[$];
   logic                    shadow_valid [TABLE_SLOTS];
   logic signed [KEY_W-1:0] shadow_key   [TABLE_SLOTS];
   logic [VALUE_W-1:0]      shadow_value [TABLE_SLOTS];
   logic signed [KEY_W-1:0] key_pool     [KEY_POOL_SIZE];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_requests;
   int unsigned holds_done;
   int unsigned hold_left;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one request to the shadow table and returns the response it owes.
   function automatic table_response_type table_access(table_request_type req);
      table_response_type rsp;
      int match;
      int free_slot;
      match     = -1;
      free_slot = -1;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (shadow_valid[i] && shadow_key[i] == req.key && match < 0) match = i;
         if (!shadow_valid[i] && free_slot < 0) free_slot = i;
      end
      rsp.status = STATUS_MISS;
      rsp.key    = req.key;
      rsp.value  = '0;
      case (req.func)
         FUNC_LOOKUP: begin
            if (match >= 0) begin
               rsp.status = STATUS_HIT;
               rsp.value  = shadow_value[match];
            end
         end
         FUNC_DELETE: begin
            if (match >= 0) begin
               rsp.status          = STATUS_HIT;
               rsp.value           = shadow_value[match];
               shadow_valid[match] = 1'b0;
            end
         end
         FUNC_INSERT: begin
            if (match >= 0) begin
               shadow_value[match] = req.value;
               rsp.status          = STATUS_UPDATED;
            end else if (free_slot >= 0) begin
               shadow_valid[free_slot] = 1'b1;
               shadow_key[free_slot]   = req.key;
               shadow_value[free_slot] = req.value;
               rsp.status              = STATUS_NEW;
            end else begin
               rsp.status = STATUS_FULL;
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // Keys mostly come from a small pool so that hits, updates and a full
   // table are common; the rest are arbitrary 32-bit keys.
   function automatic table_request_type random_request();
      table_request_type req;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40)      req.func = FUNC_INSERT;
      else if (pick < 70) req.func = FUNC_LOOKUP;
      else if (pick < 95) req.func = FUNC_DELETE;
      else                req.func = FUNC_UNUSED;
      if ($urandom_range(99) < 85) req.key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
      else                         req.key = $urandom;
      req.value = $urandom;
      return req;
   endfunction

   task automatic queue_request(logic [FUNC_W-1:0] func, logic signed [KEY_W-1:0] key,
                                logic [VALUE_W-1:0] value);
      table_request_type req;
      req.func  = func;
      req.key   = key;
      req.value = value;
      pending_requests.push_back(req);
   endtask

   task automatic wait_requests_drained();
      while (pending_requests.size() != 0) @(negedge clock);
   endtask

   // Request driver: holds an offered request until its transfer completes.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            awaited_responses.push_back(table_access(pending_requests.pop_front()));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.func  <= pending_requests[0].func;
               req_ch.key   <= pending_requests[0].key;
               req_ch.value <= pending_requests[0].value;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready, with random idling and an occasional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
      end else if (holds_done != hold_requests) begin
         holds_done   <= holds_done + 1;
         hold_left    <= LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      table_response_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: response with none awaited: status %0d key %h value %h",
                     $time, rsp_ch.status, rsp_ch.key_out, rsp_ch.value_out);
            mismatch_count++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_ch.status);
               mismatch_count++;
            end
            if (rsp_ch.key_out !== want.key) begin
               $display("%0t: key_out mismatch: expected %h, actual %h",
                        $time, want.key, rsp_ch.key_out);
               mismatch_count++;
            end
            if (rsp_ch.value_out !== want.value) begin
               $display("%0t: value_out mismatch: expected %h, actual %h",
                        $time, want.value, rsp_ch.value_out);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL key_value_table_unit");
         $finish;
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.func    = FUNC_LOOKUP;
      req_ch.key     = '0;
      req_ch.value   = '0;
      rsp_ch.ready   = 1'b0;
      send_idle_pct  = 13;
      recv_idle_pct  = 53;
      hold_requests  = 0;
      holds_done     = 0;
      hold_left      = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
      end
      key_pool[0] = 32'sh8000_0000;
      key_pool[1] = 32'sh7FFF_FFFF;
      key_pool[2] = 32'sh0000_0000;
      key_pool[3] = -32'sd1;
      for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty table, unused code, new entries at both key extremes, update,
      // delete hit and miss, then fill every slot and overflow.
      queue_request(FUNC_LOOKUP, 32'sh0000_0000, 32'hFFFF_FFFF);
      queue_request(FUNC_DELETE, -32'sd1, 32'h0);
      queue_request(FUNC_UNUSED, 32'sh7FFF_FFFF, 32'hDEAD_BEEF);
      queue_request(FUNC_INSERT, 32'sh8000_0000, 32'h0000_0000);
      queue_request(FUNC_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
      queue_request(FUNC_INSERT, 32'sh8000_0000, 32'h5A5A_5A5A);
      queue_request(FUNC_LOOKUP, 32'sh8000_0000, 32'h0);
      queue_request(FUNC_DELETE, 32'sh7FFF_FFFF, 32'h0);
      queue_request(FUNC_DELETE, 32'sh7FFF_FFFF, 32'h0);
      queue_request(FUNC_UNUSED, 32'sh8000_0000, 32'h1234_5678);
      for (int i = 0; i < TABLE_SLOTS - 1; i++) begin
         queue_request(FUNC_INSERT, 32'sh1000_0000 + i, $urandom);
      end
      queue_request(FUNC_INSERT, 32'sh2000_0000, 32'hA5A5_A5A5);

      for (int i = 0; i < RANDOM_ITEMS / 3; i++) pending_requests.push_back(random_request());
      wait_requests_drained();

      send_idle_pct = 53;
      recv_idle_pct = 13;
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) pending_requests.push_back(random_request());
      wait_requests_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); i++) begin
         pending_requests.push_back(random_request());
      end
      // Stall the response side long enough for the unit to back up its input.
      hold_requests = hold_requests + 1;

      while (pending_requests.size() != 0 || req_ch.valid || awaited_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS key_value_table_unit");
      end else begin
         $display("FAIL key_value_table_unit");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/kvt_pkg.sv
sv/kvt_req_if.sv
sv/kvt_rsp_if.sv
sv/key_value_table_unit.sv
bench/tb.sv
